// ===== hdl/mi3_pkg.sv =====
// shared types and constants for the 3x3 matrix inverse pipeline
package mi3_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned EW = 32;              // element width
  localparam int unsigned CW = 64;              // cofactor width
  localparam int unsigned TW = 96;              // one determinant term
  localparam int unsigned DETW = 98;            // determinant sum
  localparam int unsigned THRW = 31;            // threshold register width
  localparam int unsigned NEL = 9;              // elements per matrix
  localparam int unsigned DIV_STAGES = EW + 1;  // load stage plus one per quotient bit

  // operand indexes per cofactor lane: cof = m[a]*m[b] - m[c]*m[d]
  localparam int unsigned COF_IDX [NEL][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  typedef struct packed {
    logic signed [EW-1:0] in_r1c1;
    logic signed [EW-1:0] in_r1c2;
    logic signed [EW-1:0] in_r1c3;
    logic signed [EW-1:0] in_r2c1;
    logic signed [EW-1:0] in_r2c2;
    logic signed [EW-1:0] in_r2c3;
    logic signed [EW-1:0] in_r3c1;
    logic signed [EW-1:0] in_r3c2;
    logic signed [EW-1:0] in_r3c3;
  } mi3_in_t;

  typedef struct packed {
    logic signed [EW-1:0] inv_r1c1;
    logic signed [EW-1:0] inv_r1c2;
    logic signed [EW-1:0] inv_r1c3;
    logic signed [EW-1:0] inv_r2c1;
    logic signed [EW-1:0] inv_r2c2;
    logic signed [EW-1:0] inv_r2c3;
    logic signed [EW-1:0] inv_r3c1;
    logic signed [EW-1:0] inv_r3c2;
    logic signed [EW-1:0] inv_r3c3;
    logic                 singular;
    logic                 saturated;
    logic signed [EW-1:0] determinant;
  } mi3_out_t;

  // one divider lane stage
  typedef struct packed {
    logic [EW-1:0] rem;   // partial remainder
    logic [EW-1:0] nlo;   // numerator bits still to shift in
    logic [EW-1:0] q;     // quotient bits so far
    logic [EW-1:0] d;     // divisor magnitude
    logic          neg;   // result sign
    logic          ovf;   // quotient does not fit 32 bits
  } mi3_div_t;

  typedef logic [NEL-1:0][EW-1:0] mi3_mat_t;

endpackage

// ===== hdl/matrix3x3_inverse.sv =====
// 3x3 matrix inverse top level: cofactor lanes, determinant merge, divider lanes
//
//  channel   direction  signals                          request
//  in        input      in_valid_i/in_ready_o/in_data_i  one 3x3 matrix
//  out       output     out_valid_o/out_ready_i/out_data_o  inverse, flags, det
//  cfg       input      cfg_we_i/cfg_wdata_i             singular threshold write
//
//  one request per cycle sustained while out_ready_i stays high
//  the divider lanes have 33 stages (load plus one quotient bit each)
//  reset clears the stage valid bits and the threshold; payload registers are not reset
//  each stage holds its request when the one after it is full and stalled, so
//  empty stages close up and in_ready_o stays high while any stage is free
module matrix3x3_inverse #(
  parameter int unsigned FRAC_BITS = mi3_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  mi3_pkg::mi3_in_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output mi3_pkg::mi3_out_t            out_data_o,
  input  logic                         cfg_we_i,
  input  logic [mi3_pkg::THRW-1:0]     cfg_wdata_i
);
  import mi3_pkg::*;

  // pipeline stage positions
  localparam int unsigned S_PROD = 0;   // cofactor products
  localparam int unsigned S_COF  = 1;   // cofactors
  localparam int unsigned S_DETP = 2;   // determinant partial products
  localparam int unsigned S_TERM = 3;   // determinant terms
  localparam int unsigned S_DSUM = 4;   // determinant sum plus rounding half
  localparam int unsigned S_DETQ = 5;   // rounded, saturated determinant
  localparam int unsigned S_PREP = 6;   // divider load
  localparam int unsigned S_OUT  = S_PREP + DIV_STAGES;
  localparam int unsigned NS     = S_OUT + 1;

  // round half up before the shift down to element format
  localparam logic signed [DETW-1:0] HALF = DETW'(1) <<< (2 * FRAC_BITS - 1);

  typedef struct packed {
    logic [EW-1:0] det;
    logic          satd;
    logic          sing;
  } mi3_info_t;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  logic [THRW-1:0] thr_q;

  // stage enable: load when some stage at or after this one can move
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = out_ready_i | ~&v_q[NS-1:k];
  end

  assign in_ready_o  = en[S_PROD];
  assign out_valid_o = v_q[S_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      thr_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
    end
  end

  // input matrix in row-major order
  logic signed [EW-1:0] in_m [NEL];
  assign in_m[0] = in_data_i.in_r1c1;
  assign in_m[1] = in_data_i.in_r1c2;
  assign in_m[2] = in_data_i.in_r1c3;
  assign in_m[3] = in_data_i.in_r2c1;
  assign in_m[4] = in_data_i.in_r2c2;
  assign in_m[5] = in_data_i.in_r2c3;
  assign in_m[6] = in_data_i.in_r3c1;
  assign in_m[7] = in_data_i.in_r3c2;
  assign in_m[8] = in_data_i.in_r3c3;

  // matrix travels alongside for the determinant products and the singular bypass
  mi3_mat_t mat_q [NS-1];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int e = 0; e < NEL; e++) begin
        mat_q[0][e] <= in_m[e];
      end
    end
    for (int k = 1; k < NS - 1; k++) begin
      if (en[k]) begin
        mat_q[k] <= mat_q[k-1];
      end
    end
  end

  // cofactor lanes, one per adjugate entry (already transposed)
  logic signed [CW-1:0] cof [NEL];

  for (genvar l = 0; l < NEL; l++) begin : g_cof
    mi3_cof u_cof (
      .clk_i (clk_i),
      .en_i  (en[S_COF:S_PROD]),
      .a_i   (in_m[COF_IDX[l][0]]),
      .b_i   (in_m[COF_IDX[l][1]]),
      .c_i   (in_m[COF_IDX[l][2]]),
      .d_i   (in_m[COF_IDX[l][3]]),
      .cof_o (cof[l])
    );
  end

  // adjugate carried up to the divider load
  logic signed [CW-1:0] adj_q [S_DETP:S_DETQ][NEL];

  always_ff @(posedge clk_i) begin
    if (en[S_DETP]) begin
      adj_q[S_DETP] <= cof;
    end
    for (int k = S_TERM; k <= S_DETQ; k++) begin
      if (en[k]) begin
        adj_q[k] <= adj_q[k-1];
      end
    end
  end

  // determinant merge: row 1 expansion a*C11 + b*C12 + c*C13, the
  // 32x64 products split into 32x32 halves
  logic signed [EW:0]     adj_lo [3];
  logic signed [CW:0]     lo_q   [3];
  logic signed [CW-1:0]   hi_q   [3];
  logic signed [TW-1:0]   term_q [3];
  logic signed [DETW-1:0] dsum_q;

  for (genvar t = 0; t < 3; t++) begin : g_detp
    assign adj_lo[t] = $signed({1'b0, cof[3*t][EW-1:0]});

    always_ff @(posedge clk_i) begin
      if (en[S_DETP]) begin
        lo_q[t] <= $signed(mat_q[S_COF][t]) * adj_lo[t];
        hi_q[t] <= $signed(mat_q[S_COF][t]) * $signed(cof[3*t][CW-1:EW]);
      end
      if (en[S_TERM]) begin
        term_q[t] <= (TW'(hi_q[t]) <<< EW) + TW'(lo_q[t]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_DSUM]) begin
      dsum_q <= DETW'(term_q[0]) + DETW'(term_q[1]) + DETW'(term_q[2]) + HALF;
    end
  end

  // rounded determinant, clamped to the element range
  logic signed [DETW-1:0] dsh;
  logic                   dsat;
  logic [EW-1:0]          detq_d, detq_q;
  logic                   satd_q;

  assign dsh  = dsum_q >>> (2 * FRAC_BITS);
  assign dsat = ~(&dsh[DETW-1:EW-1] | ~|dsh[DETW-1:EW-1]);

  always_comb begin
    detq_d = dsh[EW-1:0];
    if (dsat) begin
      detq_d = dsh[DETW-1] ? {1'b1, {(EW-1){1'b0}}} : {1'b0, {(EW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[S_DETQ]) begin
      detq_q <= detq_d;
      satd_q <= dsat;
    end
  end

  // divider load: magnitudes, rounding offset, quotient range check
  logic [EW-1:0] ud;
  logic          sing_d;

  assign ud     = detq_q[EW-1] ? (~detq_q + 1'b1) : detq_q;
  assign sing_d = ud <= {1'b0, thr_q};

  mi3_div_t div_in  [NEL];
  mi3_div_t div_out [NEL];

  for (genvar l = 0; l < NEL; l++) begin : g_div
    logic [CW-1:0] un, num;

    assign un  = adj_q[S_DETQ][l][CW-1] ? (~adj_q[S_DETQ][l] + 1'b1) : adj_q[S_DETQ][l];
    assign num = un + CW'(ud >> 1);

    always_comb begin
      div_in[l].rem = num[CW-1:EW];
      div_in[l].nlo = num[EW-1:0];
      div_in[l].q   = '0;
      div_in[l].d   = ud;
      div_in[l].neg = adj_q[S_DETQ][l][CW-1] ^ detq_q[EW-1];
      div_in[l].ovf = num[CW-1:EW] >= ud;
    end

    mi3_div u_div (
      .clk_i (clk_i),
      .en_i  (en[S_OUT-1:S_PREP]),
      .div_i (div_in[l]),
      .div_o (div_out[l])
    );
  end

  // determinant and flags ride along with the divider lanes
  mi3_info_t info_q [S_PREP:S_OUT-1];

  always_ff @(posedge clk_i) begin
    if (en[S_PREP]) begin
      info_q[S_PREP] <= '{det: detq_q, satd: satd_q, sing: sing_d};
    end
    for (int k = S_PREP + 1; k < S_OUT; k++) begin
      if (en[k]) begin
        info_q[k] <= info_q[k-1];
      end
    end
  end

  // output merge: sign, clamp, singular bypass
  logic [EW-1:0] res  [NEL];
  logic [NEL-1:0] lsat;

  for (genvar l = 0; l < NEL; l++) begin : g_res
    always_comb begin
      if (div_out[l].neg) begin
        lsat[l] = div_out[l].ovf | (div_out[l].q > {1'b1, {(EW-1){1'b0}}});
        res[l]  = lsat[l] ? {1'b1, {(EW-1){1'b0}}} : (~div_out[l].q + 1'b1);
      end else begin
        lsat[l] = div_out[l].ovf | div_out[l].q[EW-1];
        res[l]  = lsat[l] ? {1'b0, {(EW-1){1'b1}}} : div_out[l].q;
      end
    end
  end

  mi3_info_t info_l;
  logic [EW-1:0] fin [NEL];
  mi3_out_t out_d, out_q;

  assign info_l = info_q[S_OUT-1];

  always_comb begin
    for (int e = 0; e < NEL; e++) begin
      fin[e] = info_l.sing ? mat_q[S_OUT-1][e] : res[e];
    end
    out_d.inv_r1c1    = fin[0];
    out_d.inv_r1c2    = fin[1];
    out_d.inv_r1c3    = fin[2];
    out_d.inv_r2c1    = fin[3];
    out_d.inv_r2c2    = fin[4];
    out_d.inv_r2c3    = fin[5];
    out_d.inv_r3c1    = fin[6];
    out_d.inv_r3c2    = fin[7];
    out_d.inv_r3c3    = fin[8];
    out_d.singular    = info_l.sing;
    out_d.saturated   = info_l.satd | (~info_l.sing & |lsat);
    out_d.determinant = info_l.det;
  end

  always_ff @(posedge clk_i) begin
    if (en[S_OUT]) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

  // determinant magnitude on the output, for checking
  logic [EW-1:0] out_det_mag;
  assign out_det_mag = out_q.determinant[EW-1] ? (~out_q.determinant + 1'b1)
                                               : out_q.determinant;

`ifndef SYNTH
  // a singular result really is at or below the threshold
  a_sing_thr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.singular |-> out_det_mag <= {1'b0, thr_q})
    else $error("singular flag with determinant above threshold");

  // a zero determinant never reaches the divider result
  a_zero_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.determinant == '0 |-> out_data_o.singular)
    else $error("zero determinant not flagged singular");

  // an empty first stage always takes a request
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[S_PROD] |-> in_ready_o)
    else $error("input stalled with empty first stage");
`endif

endmodule

// ===== hdl/mi3_cof.sv =====
// one cofactor lane: two registered products, then their difference
module mi3_cof (
  input  logic                           clk_i,
  input  logic [1:0]                     en_i,
  input  logic signed [mi3_pkg::EW-1:0]  a_i,
  input  logic signed [mi3_pkg::EW-1:0]  b_i,
  input  logic signed [mi3_pkg::EW-1:0]  c_i,
  input  logic signed [mi3_pkg::EW-1:0]  d_i,
  output logic signed [mi3_pkg::CW-1:0]  cof_o
);
  import mi3_pkg::*;

  logic signed [CW-1:0] pa_d, pb_d;
  logic signed [CW-1:0] pa_q, pb_q, cof_q;

  assign pa_d = a_i * b_i;
  assign pb_d = c_i * d_i;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
    end
    if (en_i[1]) begin
      cof_q <= pa_q - pb_q;
    end
  end

  assign cof_o = cof_q;

endmodule

// ===== hdl/mi3_div.sv =====
// one divider lane: restoring division, one quotient bit per stage
module mi3_div (
  input  logic                              clk_i,
  input  logic [mi3_pkg::DIV_STAGES-1:0]    en_i,
  input  mi3_pkg::mi3_div_t                 div_i,
  output mi3_pkg::mi3_div_t                 div_o
);
  import mi3_pkg::*;

  mi3_div_t st_q [DIV_STAGES];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      st_q[0] <= div_i;
    end
  end

  for (genvar j = 1; j < DIV_STAGES; j++) begin : g_stage
    mi3_div_t      src;
    logic [EW:0]   sh;
    logic          ge;

    assign src = st_q[j-1];
    assign sh  = {src.rem, src.nlo[EW-1]};
    assign ge  = sh >= {1'b0, src.d};

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        st_q[j].rem <= ge ? EW'(sh - {1'b0, src.d}) : sh[EW-1:0];
        st_q[j].nlo <= src.nlo << 1;
        st_q[j].q   <= {src.q[EW-2:0], ge};
        st_q[j].d   <= src.d;
        st_q[j].neg <= src.neg;
        st_q[j].ovf <= src.ovf;
      end
    end
  end

  assign div_o = st_q[DIV_STAGES-1];

endmodule

// ===== sim/matrix3x3_inverse_tb.sv =====
// testbench for the 3x3 matrix inverse: directed table, random matrices, scoreboard
`timescale 1ns / 1ps

module matrix3x3_inverse_tb;
  import mi3_pkg::*;

  localparam int unsigned N_RANDOM    = 1600;
  localparam int unsigned LATENCY     = 40;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic signed [31:0] ONE  = 32'sd65536;   // 1.0 in Q16.16
  localparam logic signed [31:0] EMIN = 32'sh8000_0000;
  localparam logic signed [31:0] EMAX = 32'sh7fff_ffff;
  localparam logic [30:0] THR_MAX     = 31'h7fff_ffff;

  typedef struct {
    mi3_in_t  mat;
    bit       known;     // expected result typed in below
    mi3_out_t res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  mi3_in_t     in_data_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  mi3_out_t    out_data_o;
  logic        cfg_we_i = 1'b0;
  logic [30:0] cfg_wdata_i = '0;

  // predictor copy of the threshold register
  logic [30:0] thr_model;
  mi3_out_t    inverse_q[$];
  int          mismatches = 0;
  int unsigned cycles = 0;
  bit          calm = 1'b0;      // stretch with no idling on either side

  matrix3x3_inverse dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // rounded quotient, ties away from zero, clamped to 32 bits
  function automatic logic signed [31:0] div_round(longint n, longint d, ref bit sat);
    longint unsigned un, ud, q;
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q  = (un + ud / 2) / ud;
    if ((n < 0) != (d < 0)) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        return EMIN;
      end
      return 32'(-q);
    end
    if (q > 64'h7fff_ffff) begin
      sat = 1'b1;
      return EMAX;
    end
    return 32'(q);
  endfunction

  // adjugate over rounded determinant, or pass-through when singular
  function automatic mi3_out_t predict_inverse(mi3_in_t m);
    longint e[9], adj[9], detq, dmag;
    logic signed [127:0] det, rnd;
    logic signed [31:0] r[9];
    bit sat, sing;
    mi3_out_t o;
    sat = 1'b0;
    e = '{m.in_r1c1, m.in_r1c2, m.in_r1c3, m.in_r2c1, m.in_r2c2, m.in_r2c3,
          m.in_r3c1, m.in_r3c2, m.in_r3c3};
    adj[0] = e[4] * e[8] - e[5] * e[7];
    adj[1] = e[2] * e[7] - e[1] * e[8];
    adj[2] = e[1] * e[5] - e[2] * e[4];
    adj[3] = e[5] * e[6] - e[3] * e[8];
    adj[4] = e[0] * e[8] - e[2] * e[6];
    adj[5] = e[2] * e[3] - e[0] * e[5];
    adj[6] = e[3] * e[7] - e[4] * e[6];
    adj[7] = e[1] * e[6] - e[0] * e[7];
    adj[8] = e[0] * e[4] - e[1] * e[3];
    det = 128'(signed'(e[0])) * 128'(signed'(adj[0]))
        + 128'(signed'(e[1])) * 128'(signed'(adj[3]))
        + 128'(signed'(e[2])) * 128'(signed'(adj[6]));
    // round half up at bit 31, then drop the extra 32 fraction bits
    rnd = (det + (128'sd1 <<< 31)) >>> 32;
    if (rnd > 128'sd2147483647) begin
      sat = 1'b1;
      detq = 64'sd2147483647;
    end else if (rnd < -128'sd2147483648) begin
      sat = 1'b1;
      detq = -64'sd2147483648;
    end else begin
      detq = longint'(rnd);
    end
    dmag = (detq < 0) ? -detq : detq;
    sing = dmag <= longint'(thr_model);
    for (int k = 0; k < 9; k++)
      r[k] = sing ? e[k][31:0] : div_round(adj[k], detq, sat);
    o.inv_r1c1 = r[0]; o.inv_r1c2 = r[1]; o.inv_r1c3 = r[2];
    o.inv_r2c1 = r[3]; o.inv_r2c2 = r[4]; o.inv_r2c3 = r[5];
    o.inv_r3c1 = r[6]; o.inv_r3c2 = r[7]; o.inv_r3c3 = r[8];
    o.singular    = sing;
    o.saturated   = sat;
    o.determinant = detq[31:0];
    return o;
  endfunction

  function automatic mi3_in_t diag3(logic signed [31:0] a, logic signed [31:0] b,
                                    logic signed [31:0] c);
    mi3_in_t m;
    m = '0;
    m.in_r1c1 = a; m.in_r2c2 = b; m.in_r3c3 = c;
    return m;
  endfunction

  function automatic mi3_in_t fill3(logic signed [31:0] v);
    return {9{v}};
  endfunction

  // diagonal result with zero off-diagonal entries
  function automatic mi3_out_t diag_res(logic signed [31:0] v, logic signed [31:0] d,
                                        bit sing);
    mi3_out_t o;
    o = '0;
    o.inv_r1c1 = v; o.inv_r2c2 = v; o.inv_r3c3 = v;
    o.singular = sing;
    o.determinant = d;
    return o;
  endfunction

  // singular pass-through of a matrix
  function automatic mi3_out_t echo_res(mi3_in_t m, logic signed [31:0] d);
    mi3_out_t o;
    o = {m, 1'b1, 1'b0, d};
    return o;
  endfunction

  function automatic logic signed [31:0] rand_elem(int unsigned kind);
    logic signed [31:0] v;
    case (kind)
      0: v = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;  // +-8.0
      1: v = $urandom();
      2: begin
        case ($urandom_range(0, 5))
          0: v = EMIN;
          1: v = EMAX;
          2: v = ONE;
          3: v = -ONE;
          4: v = 0;
          default: v = $urandom_range(0, 3);
        endcase
      end
      default: v = $signed($urandom_range(0, 32'h0000_1000)) - 32'sh0000_0800;
    endcase
    return v;
  endfunction

  // mostly well-conditioned small matrices, some near-dependent rows and raw noise
  function automatic mi3_in_t rand_matrix();
    mi3_in_t m;
    int unsigned pick, kind;
    pick = $urandom_range(0, 99);
    kind = (pick < 55) ? 0 : (pick < 70) ? 1 : (pick < 85) ? 2 : 3;
    m.in_r1c1 = rand_elem(kind); m.in_r1c2 = rand_elem(kind); m.in_r1c3 = rand_elem(kind);
    m.in_r2c1 = rand_elem(kind); m.in_r2c2 = rand_elem(kind); m.in_r2c3 = rand_elem(kind);
    m.in_r3c1 = rand_elem(kind); m.in_r3c2 = rand_elem(kind); m.in_r3c3 = rand_elem(kind);
    if ($urandom_range(0, 99) < 18) begin
      // third row close to the sum of the first two gives a tiny determinant
      m.in_r3c1 = m.in_r1c1 + m.in_r2c1 + $signed($urandom_range(0, 8)) - 4;
      m.in_r3c2 = m.in_r1c2 + m.in_r2c2 + $signed($urandom_range(0, 8)) - 4;
      m.in_r3c3 = m.in_r1c3 + m.in_r2c3 + $signed($urandom_range(0, 8)) - 4;
    end
    return m;
  endfunction

  // one matrix request, accepted at the edge after a negedge with ready seen high
  task automatic send_matrix(mi3_in_t m, bit known, mi3_out_t res);
    if (!calm && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (!calm && $urandom_range(0, 99) < 14) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= m;
    forever begin
      @(negedge clk_i);
      if (in_ready_o) break;
      @(posedge clk_i);
    end
    inverse_q.push_back(known ? res : predict_inverse(m));
    @(posedge clk_i);
  endtask

  // drain the pipe, then write the threshold while nothing is in flight
  task automatic set_threshold(logic [30:0] v);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    thr_model = v;
  endtask

  // result side stalls, off during the calm stretch
  always @(posedge clk_i) begin
    out_ready_i <= calm || ($urandom_range(0, 99) >= 14);
  end

  task automatic check_field(string name, longint e, longint a);
    if (e != a) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0h actual %0h", name, e, a);
    end
  endtask

  // scoreboard: outputs settle by the negedge, the handshake closes at the next edge
  always @(negedge clk_i) begin
    mi3_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (inverse_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: result with no request pending");
      end else begin
        e = inverse_q.pop_front();
        check_field("inv_r1c1", e.inv_r1c1, out_data_o.inv_r1c1);
        check_field("inv_r1c2", e.inv_r1c2, out_data_o.inv_r1c2);
        check_field("inv_r1c3", e.inv_r1c3, out_data_o.inv_r1c3);
        check_field("inv_r2c1", e.inv_r2c1, out_data_o.inv_r2c1);
        check_field("inv_r2c2", e.inv_r2c2, out_data_o.inv_r2c2);
        check_field("inv_r2c3", e.inv_r2c3, out_data_o.inv_r2c3);
        check_field("inv_r3c1", e.inv_r3c1, out_data_o.inv_r3c1);
        check_field("inv_r3c2", e.inv_r3c2, out_data_o.inv_r3c2);
        check_field("inv_r3c3", e.inv_r3c3, out_data_o.inv_r3c3);
        check_field("singular", e.singular, out_data_o.singular);
        check_field("saturated", e.saturated, out_data_o.saturated);
        check_field("determinant", e.determinant, out_data_o.determinant);
      end
    end
  end

  initial begin
    dir_row_t    dir[$];
    dir_row_t    row;
    logic [30:0] phase_thr[5];
    int unsigned per_phase;

    thr_model = '0;
    phase_thr = '{31'd0, THR_MAX, 31'd65536, 31'd0, 31'd0};
    phase_thr[3] = 31'($urandom_range(0, 32'h0000_4000));
    phase_thr[4] = 31'($urandom());
    per_phase = N_RANDOM / 5;

    // identity at reset threshold zero
    row = '{diag3(ONE, ONE, ONE), 1'b1, diag_res(ONE, ONE, 1'b0)}; dir.push_back(row);
    // negative identity
    row = '{diag3(-ONE, -ONE, -ONE), 1'b1, diag_res(-ONE, -ONE, 1'b0)}; dir.push_back(row);
    // diagonal 2.0: inverse 0.5, determinant 8.0
    row = '{diag3(2 * ONE, 2 * ONE, 2 * ONE), 1'b1,
            diag_res(ONE / 2, 8 * ONE, 1'b0)}; dir.push_back(row);
    // zero determinant is singular and echoes the input
    row = '{fill3(0), 1'b1, echo_res(fill3(0), 0)}; dir.push_back(row);
    row = '{fill3(EMIN), 1'b1, echo_res(fill3(EMIN), 0)}; dir.push_back(row);
    row = '{fill3(EMAX), 1'b1, echo_res(fill3(EMAX), 0)}; dir.push_back(row);
    row = '{fill3(-1), 1'b1, echo_res(fill3(-1), 0)}; dir.push_back(row);
    // determinant clamps high and low
    row.known = 1'b0;
    row.mat = diag3(EMAX, EMAX, EMAX); dir.push_back(row);
    row.mat = diag3(EMIN, EMIN, EMIN); dir.push_back(row);
    row.mat = diag3(EMIN, EMAX, EMAX); dir.push_back(row);
    // tiny determinants: rounding to zero and inverse saturation
    row.mat = diag3(1, 1, 1); dir.push_back(row);
    row.mat = diag3(256, 256, 65536); dir.push_back(row);
    row.mat = diag3(-256, 256, 65536); dir.push_back(row);
    row.mat = diag3(16, ONE, ONE); dir.push_back(row);
    row.mat = diag3(-16, ONE, ONE); dir.push_back(row);
    // ties in both roundings
    row.mat = diag3(3, ONE, ONE / 2); dir.push_back(row);
    row.mat = diag3(-3, ONE, ONE / 2); dir.push_back(row);
    row.mat = diag3(3 * ONE, ONE, ONE); dir.push_back(row);
    row.mat = diag3(-3 * ONE, ONE, ONE); dir.push_back(row);
    // dense mixed-sign matrices
    row.mat = {EMAX, EMIN, ONE, -ONE, EMAX, 32'sd7, EMIN, 32'sd0, EMAX}; dir.push_back(row);
    row.mat = {ONE, 2 * ONE, 3 * ONE, 32'sd0, ONE, 4 * ONE, 5 * ONE, 6 * ONE, 32'sd0};
    dir.push_back(row);
    row.mat = {32'shffff_0000, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0001_0000,
               32'sh7000_0001, 32'sh8fff_ffff, 32'sh1234_5678, 32'shedcb_a987,
               32'sh0000_ffff}; dir.push_back(row);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (dir[i]) send_matrix(dir[i].mat, dir[i].known, dir[i].res);

    for (int p = 0; p < 5; p++) begin
      set_threshold(phase_thr[p]);
      // singular at the threshold edge: determinant exactly at the new value
      if (p == 2) send_matrix(diag3(ONE, ONE, 32'sd65536), 1'b0, '0);
      for (int unsigned n = 0; n < per_phase; n++) begin
        calm = (p == 1) && (n >= 100) && (n < 250);
        send_matrix(rand_matrix(), 1'b0, '0);
      end
      calm = 1'b0;
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (inverse_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
